### src/bat_pkg.sv
// Shared types and constants for the bracket-aware tokenizer.
package bat_pkg;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_LSQUARE = 8'h5B;
	localparam logic [7:0] CH_RSQUARE = 8'h5D;
	localparam logic [7:0] CH_LCURLY  = 8'h7B;
	localparam logic [7:0] CH_RCURLY  = 8'h7D;

	localparam logic [2:0] KIND_ARRAY  = 3'd0;
	localparam logic [2:0] KIND_BLOCK  = 3'd1;
	localparam logic [2:0] KIND_INT    = 3'd2;
	localparam logic [2:0] KIND_DOUBLE = 3'd3;
	localparam logic [2:0] KIND_STRING = 3'd4;

	// One result beat.
	typedef struct packed {
		logic [7:0] byte_out;
		logic       byte_valid;
		logic       token_done;
		logic [2:0] token_kind;
		logic       unterminated;
		logic       depth_overflow;
	} res_t;

endpackage

### src/bat_engine.sv
// Token scanner state and the per-character decision logic.
module bat_engine #(
	parameter int MAX_DEPTH = 255
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        char_in,
	input  logic              end_of_input,
	output bat_pkg::res_t     res
);
	import bat_pkg::*;

	localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);
	localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_ARRAY,
		MODE_BLOCK,
		MODE_QUOTE,
		MODE_WORD
	} mode_t;

	typedef enum logic [1:0] {
		FK_OTHER,
		FK_SQUARE,
		FK_CURLY
	} first_t;

	mode_t                mode_q, mode_d;
	logic [DEPTH_W-1:0]   depth_q, depth_d;
	first_t               first_q, first_d;
	logic                 seen_q, seen_d;
	logic                 digit_q, digit_d;
	logic                 dot_q, dot_d;

	logic take, closes, opens, shuts, ovf, done;

	always_comb begin
		mode_d  = mode_q;
		depth_d = depth_q;
		first_d = first_q;
		seen_d  = seen_q;
		digit_d = digit_q;
		dot_d   = dot_q;
		take    = 1'b0;
		closes  = 1'b0;
		opens   = 1'b0;
		shuts   = 1'b0;
		ovf     = 1'b0;

		unique case (mode_q)
			MODE_IDLE: begin
				if (char_in == CH_LSQUARE) begin
					mode_d  = MODE_ARRAY;
					depth_d = DEPTH_ONE;
					take    = 1'b1;
				end else if (char_in == CH_LCURLY) begin
					mode_d  = MODE_BLOCK;
					depth_d = DEPTH_ONE;
					take    = 1'b1;
				end else if (char_in == CH_QUOTE) begin
					mode_d = MODE_QUOTE;
				end else if (char_in != CH_SPACE) begin
					mode_d = MODE_WORD;
					take   = 1'b1;
				end
			end
			MODE_ARRAY: begin
				take  = 1'b1;
				opens = (char_in == CH_LSQUARE);
				shuts = (char_in == CH_RSQUARE);
			end
			MODE_BLOCK: begin
				take  = 1'b1;
				opens = (char_in == CH_LCURLY) || (char_in == CH_LSQUARE);
				shuts = (char_in == CH_RCURLY) || (char_in == CH_RSQUARE);
			end
			MODE_QUOTE: begin
				if (char_in == CH_QUOTE) closes = 1'b1;
				else take = 1'b1;
			end
			default: begin
				if (char_in == CH_SPACE) closes = 1'b1;
				else take = 1'b1;
			end
		endcase

		// Saturating bracket depth; a close that reaches zero ends the token.
		if (opens) begin
			if (depth_q >= DEPTH_MAX) ovf = 1'b1;
			else depth_d = depth_q + DEPTH_ONE;
		end else if (shuts) begin
			if (depth_q != '0) depth_d = depth_q - DEPTH_ONE;
			closes = (depth_d == '0);
		end

		if (take) begin
			if (!seen_q) begin
				if (char_in == CH_LSQUARE) first_d = FK_SQUARE;
				else if (char_in == CH_LCURLY) first_d = FK_CURLY;
				else first_d = FK_OTHER;
				seen_d = 1'b1;
			end
			if (char_in >= CH_ZERO && char_in <= CH_NINE) digit_d = 1'b1;
			if (char_in == CH_DOT) dot_d = 1'b1;
		end

		done = (mode_d != MODE_IDLE) && (closes || end_of_input);

		res.byte_out       = take ? char_in : 8'h00;
		res.byte_valid     = take;
		res.token_done     = done;
		res.unterminated   = done && !closes && (mode_d != MODE_WORD);
		res.depth_overflow = ovf;
		if (!done) res.token_kind = KIND_ARRAY;
		else if (first_d == FK_SQUARE) res.token_kind = KIND_ARRAY;
		else if (first_d == FK_CURLY) res.token_kind = KIND_BLOCK;
		else if (digit_d) res.token_kind = dot_d ? KIND_DOUBLE : KIND_INT;
		else res.token_kind = KIND_STRING;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			depth_q <= '0;
			first_q <= FK_OTHER;
			seen_q  <= 1'b0;
			digit_q <= 1'b0;
			dot_q   <= 1'b0;
		end else if (accept) begin
			if (done || end_of_input) begin
				mode_q  <= MODE_IDLE;
				depth_q <= '0;
				first_q <= FK_OTHER;
				seen_q  <= 1'b0;
				digit_q <= 1'b0;
				dot_q   <= 1'b0;
			end else begin
				mode_q  <= mode_d;
				depth_q <= depth_d;
				first_q <= first_d;
				seen_q  <= seen_d;
				digit_q <= digit_d;
				dot_q   <= dot_d;
			end
		end
	end

endmodule

### src/bracket_aware_tokenizer.sv
// Top level of the bracket-aware tokenizer: stream ports, scanner and output skid.
// An accepted beat's result is registered in the output slot, or parked in the skid slot.
// Throughput: one character per clock while the skid slot is empty, decided combinationally.
// The output register plus a one-entry skid buffer keep input acceptance going while a
// result waits, so s_tready only drops after two results are held back by the sink.
// Reset (arst_n low) returns the scanner to idle between tokens and empties both result slots.
module bracket_aware_tokenizer #(
	parameter int MAX_DEPTH = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	// Slave side: one input character per beat.
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_in
	input  logic       s_tlast,   // end_of_input: this is the final byte of the input
	// Master side: one result per input beat.
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] byte_out
	output logic       m_tlast,   // token_done: this beat ends a token
	output logic [7:0] m_tuser    // [0] byte_valid, [3:1] token_kind, [4] unterminated,
	                              // [5] depth_overflow, [7:6] zero
);
	import bat_pkg::*;

	res_t res;
	res_t out_q, skid_q;
	logic out_valid_q, skid_valid_q;
	logic in_acc, out_free;

	// The skid slot being full is the only thing that stalls the input.
	assign s_tready = !skid_valid_q;
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	bat_engine #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_acc),
		.char_in     (s_tdata),
		.end_of_input(s_tlast),
		.res         (res)
	);

	// Slot occupancy. When the output slot frees up, a parked result moves in first;
	// otherwise a freshly scanned result goes straight to the output slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_acc;
			end
		end else if (in_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Result payload, no reset needed.
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) out_q <= skid_q;
			else if (in_acc) out_q <= res;
		end else if (in_acc) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.byte_out;
	assign m_tlast  = out_q.token_done;
	assign m_tuser  = {2'b00, out_q.depth_overflow, out_q.unterminated,
		out_q.token_kind, out_q.byte_valid};

endmodule
